// File: hw/rtl/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;

  localparam int CompW       = 16;
  localparam int WorkFrac    = 30;
  localparam int SumW        = 37;
  localparam int CordW       = 40;
  localparam int AngW        = 32;
  localparam int OutAngW     = 16;
  localparam int MagW        = 30;
  localparam int MagSqW      = 2 * MagW;
  localparam int RootW       = 31;
  localparam int RadW        = 2 * RootW;
  localparam int RemW        = 33;
  localparam int AtanEntries = 24;
  localparam int QueueDepth  = 8;
  localparam int QueuePtrW   = $clog2(QueueDepth);
  localparam int FrontStages = 3;

  localparam logic signed [SumW-1:0] WorkOne = SumW'(1) << WorkFrac;
  localparam logic [AngW-1:0] AngPi = AngW'(1) << (AngW - 1);
  localparam logic [RadW-1:0] RadOne = RadW'(1) << (2 * WorkFrac);
  localparam logic [OutAngW-1:0] PitchUp = OutAngW'(16384);
  localparam logic [OutAngW-1:0] PitchDown = OutAngW'(49152);

  // atan(2^-i), 2^31 = pi
  localparam logic [AngW-1:0] AtanTab [AtanEntries] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333771, 32'd166886, 32'd83443, 32'd41721, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [1:0] {
    PitchCordic,
    PitchPlus,
    PitchMinus
  } pitch_sel_t;

  typedef struct packed {
    logic signed [CompW-1:0] q_scalar;
    logic signed [CompW-1:0] q_i;
    logic signed [CompW-1:0] q_j;
    logic signed [CompW-1:0] q_k;
  } quat_t;

  typedef struct packed {
    logic signed [OutAngW-1:0] roll_angle;
    logic signed [OutAngW-1:0] pitch_angle;
    logic signed [OutAngW-1:0] yaw_angle;
    logic                      pitch_clamped;
  } euler_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic [AngW-1:0]         z;
    logic                    zero;
  } vec_t;

  typedef struct packed {
    vec_t                    roll;
    vec_t                    yaw;
    logic signed [CordW-1:0] a;
    logic [MagSqW-1:0]       magsq;
    pitch_sel_t              sel;
    logic                    clamped;
  } work_t;

  typedef struct packed {
    logic empty;
    logic near_full;
  } queue_stat_t;

  function automatic logic [OutAngW-1:0] to_angle16(input logic [AngW-1:0] z);
    return z[AngW-1 -: OutAngW] + OutAngW'(z[AngW-OutAngW-1]);
  endfunction

endpackage

// File: hw/rtl/quaternion_to_euler_angles.sv
// Throughput: one request per cycle while busy is low; every stage is fully pipelined.
// A request passes through the 3-stage front, the internal queue, the 32-stage square
// root, the CORDIC_STAGES CORDIC pipeline and the output register.
// busy rises only if the internal queue nears full; done cannot be stalled.
// Synchronous active-high reset clears all valid bits and the queue.
`timescale 1ns / 1ps
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  quat_t  quat,
  output logic   done,
  output euler_t euler
);

  logic        front_valid;
  work_t       front_work;
  work_t       q_rdata;
  queue_stat_t q_stat;
  logic        pop;
  logic        sq_valid;
  work_t       sq_work;
  logic [RootW-1:0] sq_root;
  vec_t        pitch_vec;
  logic [AngW-1:0] roll_z, pitch_z, yaw_z;

  logic       sb_v   [CORDIC_STAGES+1];
  pitch_sel_t sb_sel [CORDIC_STAGES+1];
  logic       sb_clp [CORDIC_STAGES+1];

  assign busy = q_stat.near_full;
  assign pop  = !q_stat.empty;

  qte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .quat     (quat),
    .out_valid(front_valid),
    .work     (front_work)
  );

  qte_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_valid),
    .wdata(front_work),
    .pop  (pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  qte_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop),
    .in_work  (q_rdata),
    .out_valid(sq_valid),
    .out_work (sq_work),
    .root     (sq_root)
  );

  assign pitch_vec.x    = CordW'(sq_root);
  assign pitch_vec.y    = sq_work.a;
  assign pitch_vec.z    = '0;
  assign pitch_vec.zero = 1'b0;

  qte_cordic #(.Stages(CORDIC_STAGES)) u_roll (
    .clk(clk), .vin(sq_work.roll), .angle(roll_z)
  );

  qte_cordic #(.Stages(CORDIC_STAGES)) u_pitch (
    .clk(clk), .vin(pitch_vec), .angle(pitch_z)
  );

  qte_cordic #(.Stages(CORDIC_STAGES)) u_yaw (
    .clk(clk), .vin(sq_work.yaw), .angle(yaw_z)
  );

  assign sb_v[0]   = sq_valid;
  assign sb_sel[0] = sq_work.sel;
  assign sb_clp[0] = sq_work.clamped;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        sb_v[i+1] <= 1'b0;
      end else begin
        sb_v[i+1] <= sb_v[i];
      end
      sb_sel[i+1] <= sb_sel[i];
      sb_clp[i+1] <= sb_clp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sb_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    euler.roll_angle    <= to_angle16(roll_z);
    euler.yaw_angle     <= to_angle16(yaw_z);
    euler.pitch_clamped <= sb_clp[CORDIC_STAGES];
    case (sb_sel[CORDIC_STAGES])
      PitchPlus:  euler.pitch_angle <= PitchUp;
      PitchMinus: euler.pitch_angle <= PitchDown;
      default:    euler.pitch_angle <= to_angle16(pitch_z);
    endcase
  end

endmodule

// File: hw/rtl/qte_front.sv
`timescale 1ns / 1ps
module qte_front import qte_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  quat_t quat,
  output logic  out_valid,
  output work_t work
);

  logic v1, v2, v3;
  logic signed [2*CompW-1:0] ss, xx, yy, zz, yz, sx, xy, sz, sy, xz;
  logic signed [SumW-1:0] rn, rd, yn, yd, a2;
  logic signed [SumW-1:0] mag_wide;
  logic [MagW-1:0] mag;
  logic [MagSqW-1:0] magsq_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ss <= quat.q_scalar * quat.q_scalar;
    xx <= quat.q_i * quat.q_i;
    yy <= quat.q_j * quat.q_j;
    zz <= quat.q_k * quat.q_k;
    yz <= quat.q_j * quat.q_k;
    sx <= quat.q_scalar * quat.q_i;
    xy <= quat.q_i * quat.q_j;
    sz <= quat.q_scalar * quat.q_k;
    sy <= quat.q_scalar * quat.q_j;
    xz <= quat.q_i * quat.q_k;
  end

  // products carry 28 fraction bits, work format has 30
  always_ff @(posedge clk) begin
    rn <= (SumW'(yz) + SumW'(sx)) <<< 3;
    yn <= (SumW'(xy) + SumW'(sz)) <<< 3;
    a2 <= (SumW'(sy) - SumW'(xz)) <<< 3;
    rd <= (SumW'(ss) + SumW'(zz) - SumW'(yy) - SumW'(xx)) <<< 2;
    yd <= (SumW'(ss) + SumW'(xx) - SumW'(yy) - SumW'(zz)) <<< 2;
  end

  assign mag_wide = (a2 < 0) ? -a2 : a2;
  assign mag      = mag_wide[MagW-1:0];
  assign magsq_c  = mag * mag;

  always_ff @(posedge clk) begin
    work.magsq    <= magsq_c;
    work.a        <= CordW'(a2);
    work.roll.zero <= (rd == 0) && (rn == 0);
    work.yaw.zero  <= (yd == 0) && (yn == 0);
    if (rd < 0) begin
      work.roll.x <= -CordW'(rd);
      work.roll.y <= -CordW'(rn);
      work.roll.z <= AngPi;
    end else begin
      work.roll.x <= CordW'(rd);
      work.roll.y <= CordW'(rn);
      work.roll.z <= '0;
    end
    if (yd < 0) begin
      work.yaw.x <= -CordW'(yd);
      work.yaw.y <= -CordW'(yn);
      work.yaw.z <= AngPi;
    end else begin
      work.yaw.x <= CordW'(yd);
      work.yaw.y <= CordW'(yn);
      work.yaw.z <= '0;
    end
    if (a2 > WorkOne) begin
      work.sel     <= PitchPlus;
      work.clamped <= 1'b1;
    end else if (a2 < -WorkOne) begin
      work.sel     <= PitchMinus;
      work.clamped <= 1'b1;
    end else if (a2 == WorkOne) begin
      work.sel     <= PitchPlus;
      work.clamped <= 1'b0;
    end else if (a2 == -WorkOne) begin
      work.sel     <= PitchMinus;
      work.clamped <= 1'b0;
    end else begin
      work.sel     <= PitchCordic;
      work.clamped <= 1'b0;
    end
  end

  assign out_valid = v3;

endmodule

// File: hw/rtl/qte_queue.sv
`timescale 1ns / 1ps
module qte_queue import qte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  work_t       wdata,
  input  logic        pop,
  output work_t       rdata,
  output queue_stat_t stat
);

  work_t mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [QueuePtrW:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
  end

  assign rdata          = mem[rd_ptr];
  assign stat.empty     = (count == '0);
  // leave room for requests still in the front stages
  assign stat.near_full = (count >= (QueuePtrW+1)'(QueueDepth - FrontStages));

endmodule

// File: hw/rtl/qte_isqrt.sv
`timescale 1ns / 1ps
module qte_isqrt import qte_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  work_t            in_work,
  output logic             out_valid,
  output work_t            out_work,
  output logic [RootW-1:0] root
);

  logic             v_s    [RootW+1];
  work_t            w_s    [RootW+1];
  logic [RadW-1:0]  n_s    [RootW+1];
  logic [RemW-1:0]  rem_s  [RootW+1];
  logic [RootW-1:0] root_s [RootW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else begin
      v_s[0] <= in_valid;
    end
    w_s[0]    <= in_work;
    n_s[0]    <= RadOne - RadW'(in_work.magsq);
    rem_s[0]  <= '0;
    root_s[0] <= '0;
  end

  for (genvar k = 0; k < RootW; k++) begin : g_step
    logic [RemW+1:0] remt, trial, diff;
    logic            ge;

    assign remt  = {rem_s[k], n_s[k][RadW-1 -: 2]};
    assign trial = {2'b00, root_s[k], 2'b01};
    assign diff  = remt - trial;
    assign ge    = (remt >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else begin
        v_s[k+1] <= v_s[k];
      end
      w_s[k+1]    <= w_s[k];
      n_s[k+1]    <= n_s[k] << 2;
      rem_s[k+1]  <= ge ? diff[RemW-1:0] : remt[RemW-1:0];
      root_s[k+1] <= {root_s[k][RootW-2:0], ge};
    end
  end

  assign out_valid = v_s[RootW];
  assign out_work  = w_s[RootW];
  assign root      = root_s[RootW];

endmodule

// File: hw/rtl/qte_cordic.sv
`timescale 1ns / 1ps
module qte_cordic import qte_pkg::*; #(
  parameter int Stages = 16
) (
  input  logic            clk,
  input  vec_t            vin,
  output logic [AngW-1:0] angle
);

  vec_t v [Stages+1];

  assign v[0] = vin;

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    logic signed [CordW-1:0] dx, dy;

    assign dx = v[i].y >>> i;
    assign dy = v[i].x >>> i;

    always_ff @(posedge clk) begin
      v[i+1].zero <= v[i].zero;
      if (v[i].y >= 0) begin
        v[i+1].x <= v[i].x + dx;
        v[i+1].y <= v[i].y - dy;
        v[i+1].z <= v[i].z + AtanTab[i];
      end else begin
        v[i+1].x <= v[i].x - dx;
        v[i+1].y <= v[i].y + dy;
        v[i+1].z <= v[i].z - AtanTab[i];
      end
    end
  end

  assign angle = v[Stages].zero ? '0 : v[Stages].z;

endmodule

// File: hw/rtl/qte_checker.sv
`timescale 1ns / 1ps
module qte_checker import qte_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input logic   clk,
  input logic   rst,
  input logic   start,
  input logic   busy,
  input logic   done,
  input euler_t euler
);

  localparam int Latency = CORDIC_STAGES + 37;

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised under a continuous request stream");

  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Latency))
    else $error("done without a request at the pipeline latency");

  a_clamp_saturates: assert property (@(posedge clk) disable iff (rst)
    done && euler.pitch_clamped |->
      (euler.pitch_angle == 16'sd16384) || (euler.pitch_angle == -16'sd16384))
    else $error("clamped pitch not at a pole");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (euler.pitch_angle <= 16'sd16384) && (euler.pitch_angle >= -16'sd16384))
    else $error("pitch outside half turn");

endmodule

bind quaternion_to_euler_angles qte_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .euler(euler)
);

// File: tb/sv/quaternion_to_euler_angles_tb.sv
`timescale 1ns / 1ps
module quaternion_to_euler_angles_tb;
  import qte_pkg::*;

  localparam int Stages = 16;
  localparam int Latency = Stages + 37;
  localparam int Limit = 20 * Latency + 200;
  localparam int NumRandom = 730;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  quat_t quat = '0;
  euler_t euler;

  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int clamped_seen = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  always #5 clk = ~clk;

  quaternion_to_euler_angles #(.CORDIC_STAGES(Stages)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat(quat), .done(done), .euler(euler)
  );

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %0s: got %0d expected %0d (result %0d) at %0t",
             what, got, want, checked, $realtime);
    errors++;
  endtask

  // Arithmetic right shift, toward minus infinity
  function automatic longint shr(input longint v, input int k);
    return v >>> k;
  endfunction

  function automatic longint prod30(input longint a, input longint b);
    return (a * b) <<< 2;
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] vector_angle(input longint yv, input longint xv);
    logic [31:0] ang;
    longint dx, dy;
    ang = '0;
    if (xv == 0 && yv == 0) return '0;
    if (xv < 0) begin
      xv = -xv;
      yv = -yv;
      ang = AngPi;
    end
    for (int i = 0; i < Stages && i < AtanEntries; i++) begin
      dx = shr(yv, i);
      dy = shr(xv, i);
      if (yv >= 0) begin
        xv += dx;
        yv -= dy;
        ang += AtanTab[i];
      end else begin
        xv -= dx;
        yv += dy;
        ang -= AtanTab[i];
      end
    end
    return ang;
  endfunction

  function automatic logic [15:0] round16(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h8000;
    return t[31:16];
  endfunction

  function automatic euler_t euler_of(input quat_t q);
    euler_t e;
    longint s, x, y, z, one, rn, rd, yn, yd, a;
    longint unsigned mag;
    s = longint'(q.q_scalar);
    x = longint'(q.q_i);
    y = longint'(q.q_j);
    z = longint'(q.q_k);
    one = longint'(1) << WorkFrac;
    rn = 2 * (prod30(y, z) + prod30(s, x));
    rd = prod30(s, s) + prod30(z, z) - prod30(y, y) - prod30(x, x);
    yn = 2 * (prod30(x, y) + prod30(s, z));
    yd = prod30(s, s) + prod30(x, x) - prod30(y, y) - prod30(z, z);
    a = 2 * (prod30(s, y) - prod30(x, z));
    e.pitch_clamped = 1'b0;
    if (a >= one) begin
      e.pitch_angle = 16'sd16384;
      e.pitch_clamped = (a > one);
    end else if (a <= -one) begin
      e.pitch_angle = -16'sd16384;
      e.pitch_clamped = (a < -one);
    end else begin
      mag = (a < 0) ? longint'(-a) : longint'(a);
      e.pitch_angle = round16(vector_angle(a,
                       longint'(root64((64'd1 << (2 * WorkFrac)) - mag * mag))));
    end
    e.roll_angle = round16(vector_angle(rn, rd));
    e.yaw_angle = round16(vector_angle(yn, yd));
    return e;
  endfunction

  class euler_board;
    euler_t pending[$];

    function void note_request(input quat_t q);
      pending.push_back(euler_of(q));
    endfunction

    task check_result(input euler_t got);
      euler_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.roll_angle, 0);
        return;
      end
      want = pending.pop_front();
      if (got.roll_angle !== want.roll_angle)
        report("roll", got.roll_angle, want.roll_angle);
      if (got.pitch_angle !== want.pitch_angle)
        report("pitch", got.pitch_angle, want.pitch_angle);
      if (got.yaw_angle !== want.yaw_angle)
        report("yaw", got.yaw_angle, want.yaw_angle);
      if (got.pitch_clamped !== want.pitch_clamped)
        report("clamp", got.pitch_clamped, want.pitch_clamped);
      if (want.pitch_clamped) clamped_seen++;
      checked++;
    endtask
  endclass

  euler_board board = new();

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        board.note_request(quat);
        accepted++;
      end
      if (done) board.check_result(euler);
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= Limit) begin
        $display("timeout waiting on the block");
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // busy only moves at rising edges, so its value at a falling edge holds
  // for the next rising edge
  task automatic send(input quat_t q);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    quat <= q;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] comp(input real v);
    return 16'(int'(v * 16384.0));
  endfunction

  function automatic quat_t rand_quat();
    quat_t q;
    real n, c[4];
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) return quat_t'({$urandom, $urandom});
    if (mode < 4) begin
      q.q_scalar = 16'($signed($urandom_range(0, 400)) - 200);
      q.q_i = 16'($signed($urandom_range(0, 400)) - 200);
      q.q_j = 16'($signed($urandom_range(0, 400)) - 200);
      q.q_k = 16'($signed($urandom_range(0, 400)) - 200);
      return q;
    end
    // near-unit quaternions, the usual operating point
    n = 0.0;
    foreach (c[i]) begin
      c[i] = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
      n += c[i] * c[i];
    end
    if (n < 1e-6) n = 1.0;
    n = $sqrt(n) * (mode == 9 ? 0.9 : 1.0);
    q.q_scalar = comp(c[0] / n);
    q.q_i = comp(c[1] / n);
    q.q_j = comp(c[2] / n);
    q.q_k = comp(c[3] / n);
    return q;
  endfunction

  initial begin
    quat_t q;
    int wait_cnt;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send('0);
    send('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    send('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    send('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    send('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    send('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    send('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
    send('{16'sd11585, 16'sd0, -16'sd11585, 16'sd0});
    send('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
    send('{16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192});
    send('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send('{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000});
    send('{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000});
    send('{-16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send('{16'sd16384, 16'sd0, 16'sd16384, 16'sd0});
    send('{-16'sd16384, 16'sd0, 16'sd16384, 16'sd0});
    send('{16'sd0, -16'sd16384, 16'sd0, 16'sd16384});
    send('{16'sd0, 16'sd0, 16'sd0, -16'sd16384});
    send('{16'sd1, 16'sd0, 16'sd0, 16'sd0});
    send('{-16'sd1, -16'sd1, 16'sd1, -16'sd1});
    send('{16'sd0, 16'sd5000, 16'sd0, 16'sd0});
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - 150) gaps_on = 1'b0;
      q = rand_quat();
      send(q);
    end
    start <= 1'b0;
    wait_cnt = 0;
    while (board.pending.size() != 0 && wait_cnt < Limit) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (Latency + 10) @(posedge clk);
    $display("%0d quaternions sent, %0d results checked, %0d with clamped pitch",
             accepted, checked, clamped_seen);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, board.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
